// ===== rtl/core/mpf_pkg.sv =====
// Shared types, constants and field arithmetic helpers for the prime field unit.
package mpf_pkg;

    // Field element and exponent widths.
    localparam int VALUE_BITS   = 61;
    localparam int EXP_BITS     = 63;
    localparam int MODE_BITS    = 3;
    localparam int NONRES_LIMIT = 4096;

    // Counter widths for the square root bookkeeping.
    localparam int CNT_BITS = $clog2(VALUE_BITS + 2);
    localparam int J_BITS   = $clog2(NONRES_LIMIT + 1);
    localparam int SUM_BITS = ((J_BITS > CNT_BITS) ? J_BITS : CNT_BITS) + 1;

    // Stream packing, first field in the lowest bits.
    localparam int A_LSB      = MODE_BITS;
    localparam int B_LSB      = A_LSB + VALUE_BITS;
    localparam int E_LSB      = B_LSB + VALUE_BITS;
    localparam int IN_BITS    = E_LSB + EXP_BITS;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int SYM_LSB    = VALUE_BITS;
    localparam int EQ_BIT     = SYM_LSB + 2;
    localparam int ERR_LSB    = EQ_BIT + 1;
    localparam int OUT_BITS   = ERR_LSB + 2;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [VALUE_BITS-1:0] elem_t;
    typedef logic [EXP_BITS-1:0]   exp_t;

    typedef enum logic [2:0] {
        MODE_ADD, MODE_SUB, MODE_MUL, MODE_NEG,
        MODE_POW, MODE_DIV, MODE_LEG, MODE_SQRT
    } mode_t;

    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_RANGE  = 2'd1;
    localparam logic [1:0] ERR_NONRES = 2'd2;
    localparam logic [1:0] SYM_ZERO   = 2'b00;
    localparam logic [1:0] SYM_POS    = 2'b01;
    localparam logic [1:0] SYM_NEG    = 2'b11;

    // Register selectors for multiplier operands, destinations and captures.
    typedef enum logic [3:0] {
        SRC_A, SRC_B, SRC_X, SRC_Y, SRC_R, SRC_T, SRC_C, SRC_BV, SRC_TS, SRC_Z, SRC_RES
    } src_t;

    // Exponent choices for a power run.
    typedef enum logic [2:0] {
        EXP_IN, EXP_PM2, EXP_PH, EXP_P1Q, EXP_Q, EXP_QH
    } exp_sel_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_ADD, OP_SUB, OP_NEG, OP_ERR_RANGE, OP_ERR_NONRES,
        OP_RES_Y, OP_RES_R, OP_RES_ONE, OP_SYM_POS, OP_SYM_Y, OP_POW_SETUP,
        OP_KSHIFT, OP_QINIT, OP_QSHIFT, OP_ZINIT, OP_ZINC, OP_B_FROM_C, OP_PUSH
    } dp_op_t;

    typedef enum logic [2:0] {
        CNT_NONE, CNT_I_ONE, CNT_I_INC, CNT_J_ZERO, CNT_J_INC, CNT_M_S, CNT_M_I
    } cnt_op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_MWAIT, ST_PCHK, ST_PSQ, ST_PSHIFT, ST_POW_DONE,
        ST_DIV_MUL, ST_LEG_DONE, ST_SQ_LEG, ST_SQ_QS, ST_NR_TEST, ST_NR_CHK,
        ST_NR_NEXT, ST_GOT_C, ST_GOT_R, ST_GOT_T, ST_TLOOP, ST_ISQ, ST_BLOOP,
        ST_UPD_T1, ST_UPD_T2, ST_UPD_C, ST_PUSH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        dp_op_t   op;
        cnt_op_t  cnt_op;
        logic     cap_en;
        src_t     cap_dest;
        src_t     base_sel;
        exp_sel_t exp_sel;
        logic     mul_start;
        src_t     mul_a;
        src_t     mul_b;
        src_t     mul_dest;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        mode_t mode;
        logic  a_ge_p;
        logic  b_ge_p;
        logic  a_zero;
        logic  p_two;
        logic  k_zero;
        logic  k_lsb;
        logic  y_one;
        logic  q_even;
        logic  s_one;
        logic  z_zero;
        logic  j_at_limit;
        logic  t_one;
        logic  ts_one;
        logic  i_ge_m;
        logic  i1_ge_m;
        logic  b_go;
        logic  mul_busy;
    } dp_status_t;

    // Modular add of two reduced values.
    function automatic elem_t add_m(input elem_t x, input elem_t y, input elem_t p);
        logic [VALUE_BITS:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, p}) begin
            s = s - {1'b0, p};
        end
        return s[VALUE_BITS-1:0];
    endfunction

    // Modular subtract of two reduced values.
    function automatic elem_t sub_m(input elem_t x, input elem_t y, input elem_t p);
        return (x >= y) ? (x - y) : (x + (p - y));
    endfunction

endpackage

// ===== rtl/core/modular_prime_field_alu.sv =====
// Top level of the prime field arithmetic unit: stream ports, controller and datapath.
// One item is taken at a time and gives one result. All products run on a single
// double-and-add multiplier, so add, subtract and negate need no product, multiply
// takes one, power one squaring per exponent bit plus one product per set bit,
// divide a power to p-2 and one product, Legendre one power, about as long as
// divide, and square root from one power up to many powers and products when p-1
// holds a high power of two. The input is accepted again while the previous
// result still waits in the output register.
module modular_prime_field_alu (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  mpf_pkg::elem_t                    cfg_wr_data,   // modulus
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mpf_pkg::IN_DATA_W-1:0]     s_tdata,       // mode, operand_a, operand_b, exponent
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mpf_pkg::OUT_DATA_W-1:0]    m_tdata        // value, symbol, equal, error
);

    mpf_pkg::dp_cmd_t    cmd;
    mpf_pkg::dp_status_t status;

    mpf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    mpf_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .out_data    (m_tdata)
    );

endmodule

// ===== rtl/core/mpf_datapath.sv =====
// Datapath: operand and working registers, serial modular multiplier, output register.
module mpf_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  mpf_pkg::elem_t                      cfg_wr_data,
    input  logic [mpf_pkg::IN_DATA_W-1:0]       in_data,
    input  mpf_pkg::dp_cmd_t                    cmd,
    output mpf_pkg::dp_status_t                 status,
    output logic [mpf_pkg::OUT_DATA_W-1:0]      out_data
);

    localparam int MCNT_BITS = $clog2(mpf_pkg::VALUE_BITS);

    mpf_pkg::elem_t p_reg;
    mpf_pkg::elem_t a_reg, b_reg, x_reg, y_reg, r_reg, t_reg, c_reg, bv_reg, ts_reg, z_reg;
    mpf_pkg::elem_t q_reg, res_reg;
    mpf_pkg::exp_t  e_reg, k_reg;
    mpf_pkg::mode_t mode_reg;
    logic [1:0]     sym_reg, err_reg;
    logic [mpf_pkg::CNT_BITS-1:0] s_reg, m_reg, i_reg;
    logic [mpf_pkg::J_BITS-1:0]   j_reg;

    // Serial multiplier state.
    logic                 mul_busy_reg;
    logic [MCNT_BITS-1:0] mul_cnt_reg;
    mpf_pkg::elem_t       mul_x_reg, mul_y_reg, mul_acc_reg;
    mpf_pkg::src_t        mul_dest_reg;

    logic [mpf_pkg::OUT_DATA_W-1:0] out_reg;

    mpf_pkg::elem_t mul_a_val, mul_b_val, base_val, cap_val, mul_dbl, mul_step;
    mpf_pkg::exp_t  exp_val;
    logic [mpf_pkg::VALUE_BITS:0] p_plus1, q_plus1;
    logic [mpf_pkg::SUM_BITS-1:0] b_sum;

    // Register selection for the multiplier and for power setup.
    function automatic mpf_pkg::elem_t pick(input mpf_pkg::src_t sel,
            input mpf_pkg::elem_t a, input mpf_pkg::elem_t b, input mpf_pkg::elem_t x,
            input mpf_pkg::elem_t y, input mpf_pkg::elem_t r, input mpf_pkg::elem_t t,
            input mpf_pkg::elem_t c, input mpf_pkg::elem_t bv, input mpf_pkg::elem_t ts,
            input mpf_pkg::elem_t z);
        mpf_pkg::elem_t v;
        unique case (sel)
            mpf_pkg::SRC_A:  v = a;
            mpf_pkg::SRC_B:  v = b;
            mpf_pkg::SRC_X:  v = x;
            mpf_pkg::SRC_Y:  v = y;
            mpf_pkg::SRC_R:  v = r;
            mpf_pkg::SRC_T:  v = t;
            mpf_pkg::SRC_C:  v = c;
            mpf_pkg::SRC_BV: v = bv;
            mpf_pkg::SRC_TS: v = ts;
            mpf_pkg::SRC_Z:  v = z;
            default:         v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        mul_a_val = pick(cmd.mul_a, a_reg, b_reg, x_reg, y_reg, r_reg, t_reg, c_reg,
                         bv_reg, ts_reg, z_reg);
        mul_b_val = pick(cmd.mul_b, a_reg, b_reg, x_reg, y_reg, r_reg, t_reg, c_reg,
                         bv_reg, ts_reg, z_reg);
        base_val  = pick(cmd.base_sel, a_reg, b_reg, x_reg, y_reg, r_reg, t_reg, c_reg,
                         bv_reg, ts_reg, z_reg);
    end

    // Exponent taken from the input or derived from the modulus or from q.
    assign p_plus1 = {1'b0, p_reg} + 1'b1;
    assign q_plus1 = {1'b0, q_reg} + 1'b1;
    always_comb begin
        unique case (cmd.exp_sel)
            mpf_pkg::EXP_IN:  exp_val = e_reg;
            mpf_pkg::EXP_PM2: exp_val = mpf_pkg::EXP_BITS'(p_reg - 2'd2);
            mpf_pkg::EXP_PH:  exp_val = mpf_pkg::EXP_BITS'((p_reg - 1'b1) >> 1);
            mpf_pkg::EXP_P1Q: exp_val = mpf_pkg::EXP_BITS'(p_plus1 >> 2);
            mpf_pkg::EXP_Q:   exp_val = mpf_pkg::EXP_BITS'(q_reg);
            mpf_pkg::EXP_QH:  exp_val = mpf_pkg::EXP_BITS'(q_plus1 >> 1);
            default:          exp_val = '0;
        endcase
    end

    // One double-and-add step of the multiplier, top multiplier bit first.
    assign mul_dbl  = mpf_pkg::add_m(mul_acc_reg, mul_acc_reg, p_reg);
    assign mul_step = mul_y_reg[mpf_pkg::VALUE_BITS-1]
                      ? mpf_pkg::add_m(mul_dbl, mul_x_reg, p_reg) : mul_dbl;

    assign cap_val = y_reg;

    // Modulus register and multiplier control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg        <= mpf_pkg::elem_t'(2);
            mul_busy_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                p_reg <= (cfg_wr_data < mpf_pkg::elem_t'(2)) ? mpf_pkg::elem_t'(2)
                                                              : cfg_wr_data;
            end
            if (cmd.mul_start) begin
                mul_busy_reg <= 1'b1;
            end else if (mul_busy_reg && mul_cnt_reg == '0) begin
                mul_busy_reg <= 1'b0;
            end
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        // Multiplier sequencing and result write-back.
        if (cmd.mul_start) begin
            mul_x_reg    <= mul_a_val;
            mul_y_reg    <= mul_b_val;
            mul_acc_reg  <= '0;
            mul_cnt_reg  <= MCNT_BITS'(mpf_pkg::VALUE_BITS - 1);
            mul_dest_reg <= cmd.mul_dest;
        end else if (mul_busy_reg) begin
            mul_acc_reg <= mul_step;
            mul_y_reg   <= mul_y_reg << 1;
            mul_cnt_reg <= mul_cnt_reg - 1'b1;
            if (mul_cnt_reg == '0) begin
                case (mul_dest_reg)
                    mpf_pkg::SRC_X:   x_reg   <= mul_step;
                    mpf_pkg::SRC_Y:   y_reg   <= mul_step;
                    mpf_pkg::SRC_R:   r_reg   <= mul_step;
                    mpf_pkg::SRC_T:   t_reg   <= mul_step;
                    mpf_pkg::SRC_C:   c_reg   <= mul_step;
                    mpf_pkg::SRC_BV:  bv_reg  <= mul_step;
                    mpf_pkg::SRC_TS:  ts_reg  <= mul_step;
                    mpf_pkg::SRC_RES: res_reg <= mul_step;
                    default: ;
                endcase
            end
        end

        // Capture of a finished power into a named register.
        if (cmd.cap_en) begin
            case (cmd.cap_dest)
                mpf_pkg::SRC_R: r_reg <= cap_val;
                mpf_pkg::SRC_T: t_reg <= cap_val;
                mpf_pkg::SRC_C: c_reg <= cap_val;
                default: ;
            endcase
        end

        // Counters.
        case (cmd.cnt_op)
            mpf_pkg::CNT_I_ONE:  i_reg <= mpf_pkg::CNT_BITS'(1);
            mpf_pkg::CNT_I_INC:  i_reg <= i_reg + 1'b1;
            mpf_pkg::CNT_J_ZERO: j_reg <= '0;
            mpf_pkg::CNT_J_INC:  j_reg <= j_reg + 1'b1;
            mpf_pkg::CNT_M_S:    m_reg <= s_reg;
            mpf_pkg::CNT_M_I:    m_reg <= i_reg;
            default: ;
        endcase

        // Register updates selected by the op command.
        unique case (cmd.op)
            mpf_pkg::OP_LOAD: begin
                mode_reg <= mpf_pkg::mode_t'(in_data[mpf_pkg::MODE_BITS-1:0]);
                a_reg    <= in_data[mpf_pkg::A_LSB +: mpf_pkg::VALUE_BITS];
                b_reg    <= in_data[mpf_pkg::B_LSB +: mpf_pkg::VALUE_BITS];
                e_reg    <= in_data[mpf_pkg::E_LSB +: mpf_pkg::EXP_BITS];
                res_reg  <= '0;
                sym_reg  <= mpf_pkg::SYM_ZERO;
                err_reg  <= mpf_pkg::ERR_OK;
            end
            mpf_pkg::OP_ADD:        res_reg <= mpf_pkg::add_m(a_reg, b_reg, p_reg);
            mpf_pkg::OP_SUB:        res_reg <= mpf_pkg::sub_m(a_reg, b_reg, p_reg);
            mpf_pkg::OP_NEG:        res_reg <= (a_reg == '0) ? '0 : (p_reg - a_reg);
            mpf_pkg::OP_ERR_RANGE:  err_reg <= mpf_pkg::ERR_RANGE;
            mpf_pkg::OP_ERR_NONRES: err_reg <= mpf_pkg::ERR_NONRES;
            mpf_pkg::OP_RES_Y:      res_reg <= y_reg;
            mpf_pkg::OP_RES_R:      res_reg <= r_reg;
            mpf_pkg::OP_RES_ONE:    res_reg <= mpf_pkg::elem_t'(1);
            mpf_pkg::OP_SYM_POS:    sym_reg <= mpf_pkg::SYM_POS;
            mpf_pkg::OP_SYM_Y:
                sym_reg <= (y_reg == mpf_pkg::elem_t'(1)) ? mpf_pkg::SYM_POS : mpf_pkg::SYM_NEG;
            mpf_pkg::OP_POW_SETUP: begin
                x_reg <= base_val;
                k_reg <= exp_val;
                y_reg <= mpf_pkg::elem_t'(1);
            end
            mpf_pkg::OP_KSHIFT: k_reg <= k_reg >> 1;
            mpf_pkg::OP_QINIT: begin
                q_reg <= p_reg - 1'b1;
                s_reg <= '0;
            end
            mpf_pkg::OP_QSHIFT: begin
                q_reg <= q_reg >> 1;
                s_reg <= s_reg + 1'b1;
            end
            mpf_pkg::OP_ZINIT:     z_reg  <= mpf_pkg::elem_t'(2);
            mpf_pkg::OP_ZINC:      z_reg  <= mpf_pkg::add_m(z_reg, mpf_pkg::elem_t'(1), p_reg);
            mpf_pkg::OP_B_FROM_C:  bv_reg <= c_reg;
            mpf_pkg::OP_PUSH: begin
                out_reg <= {{(mpf_pkg::OUT_DATA_W - mpf_pkg::OUT_BITS){1'b0}},
                            err_reg, (a_reg == b_reg), sym_reg, res_reg};
            end
            default: ;
        endcase
    end

    assign b_sum = mpf_pkg::SUM_BITS'(j_reg) + mpf_pkg::SUM_BITS'(i_reg) + 1'b1;

    // Status flags for the controller.
    always_comb begin
        status.mode       = mode_reg;
        status.a_ge_p     = (a_reg >= p_reg);
        status.b_ge_p     = (b_reg >= p_reg);
        status.a_zero     = (a_reg == '0);
        status.p_two      = (p_reg == mpf_pkg::elem_t'(2));
        status.k_zero     = (k_reg == '0);
        status.k_lsb      = k_reg[0];
        status.y_one      = (y_reg == mpf_pkg::elem_t'(1));
        status.q_even     = ~q_reg[0];
        status.s_one      = (s_reg == mpf_pkg::CNT_BITS'(1));
        status.z_zero     = (z_reg == '0);
        status.j_at_limit = (j_reg >= mpf_pkg::J_BITS'(mpf_pkg::NONRES_LIMIT));
        status.t_one      = (t_reg == mpf_pkg::elem_t'(1));
        status.ts_one     = (ts_reg == mpf_pkg::elem_t'(1));
        status.i_ge_m     = (i_reg >= m_reg);
        status.i1_ge_m    = ({1'b0, i_reg} + 1'b1 >= {1'b0, m_reg});
        status.b_go       = (b_sum < mpf_pkg::SUM_BITS'(m_reg));
        status.mul_busy   = mul_busy_reg;
    end

    assign out_data = out_reg;

endmodule

// ===== rtl/core/mpf_ctrl.sv =====
// Controller: sequences each operation, power runs and Tonelli-Shanks over the datapath.
module mpf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  mpf_pkg::dp_status_t status,
    output mpf_pkg::dp_cmd_t    cmd
);

    mpf_pkg::state_t state_reg, state_next;
    mpf_pkg::state_t after_reg, after_next;
    mpf_pkg::state_t ret_reg, ret_next;
    logic            out_valid_reg, out_valid_next;
    logic            uses_b;

    // State, return points and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mpf_pkg::ST_IDLE;
            after_reg     <= mpf_pkg::ST_IDLE;
            ret_reg       <= mpf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            after_reg     <= after_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        case (status.mode)
            mpf_pkg::MODE_ADD, mpf_pkg::MODE_SUB, mpf_pkg::MODE_MUL, mpf_pkg::MODE_DIV:
                uses_b = 1'b1;
            default: uses_b = 1'b0;
        endcase
    end

    // Next state and commands.
    always_comb begin
        state_next     = state_reg;
        after_next     = after_reg;
        ret_next       = ret_reg;
        cmd            = '0;
        cmd.op         = mpf_pkg::OP_NOP;
        cmd.cnt_op     = mpf_pkg::CNT_NONE;
        cmd.exp_sel    = mpf_pkg::EXP_IN;
        cmd.base_sel   = mpf_pkg::SRC_A;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg & ~out_ready;

        unique case (state_reg)
            mpf_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.op     = mpf_pkg::OP_LOAD;
                    state_next = mpf_pkg::ST_CHECK;
                end
            end
            mpf_pkg::ST_CHECK: begin
                if (status.a_ge_p || (uses_b && status.b_ge_p)) begin
                    cmd.op     = mpf_pkg::OP_ERR_RANGE;
                    state_next = mpf_pkg::ST_PUSH;
                end else begin
                    unique case (status.mode)
                        mpf_pkg::MODE_ADD: begin
                            cmd.op     = mpf_pkg::OP_ADD;
                            state_next = mpf_pkg::ST_PUSH;
                        end
                        mpf_pkg::MODE_SUB: begin
                            cmd.op     = mpf_pkg::OP_SUB;
                            state_next = mpf_pkg::ST_PUSH;
                        end
                        mpf_pkg::MODE_NEG: begin
                            cmd.op     = mpf_pkg::OP_NEG;
                            state_next = mpf_pkg::ST_PUSH;
                        end
                        mpf_pkg::MODE_MUL: begin
                            cmd.mul_start = 1'b1;
                            cmd.mul_a     = mpf_pkg::SRC_A;
                            cmd.mul_b     = mpf_pkg::SRC_B;
                            cmd.mul_dest  = mpf_pkg::SRC_RES;
                            after_next    = mpf_pkg::ST_PUSH;
                            state_next    = mpf_pkg::ST_MWAIT;
                        end
                        mpf_pkg::MODE_POW: begin
                            cmd.op     = mpf_pkg::OP_POW_SETUP;
                            ret_next   = mpf_pkg::ST_POW_DONE;
                            state_next = mpf_pkg::ST_PCHK;
                        end
                        mpf_pkg::MODE_DIV: begin
                            cmd.op       = mpf_pkg::OP_POW_SETUP;
                            cmd.base_sel = mpf_pkg::SRC_B;
                            cmd.exp_sel  = mpf_pkg::EXP_PM2;
                            ret_next     = mpf_pkg::ST_DIV_MUL;
                            state_next   = mpf_pkg::ST_PCHK;
                        end
                        mpf_pkg::MODE_LEG: begin
                            if (status.a_zero) begin
                                state_next = mpf_pkg::ST_PUSH;
                            end else if (status.p_two) begin
                                cmd.op     = mpf_pkg::OP_SYM_POS;
                                state_next = mpf_pkg::ST_PUSH;
                            end else begin
                                cmd.op      = mpf_pkg::OP_POW_SETUP;
                                cmd.exp_sel = mpf_pkg::EXP_PH;
                                ret_next    = mpf_pkg::ST_LEG_DONE;
                                state_next  = mpf_pkg::ST_PCHK;
                            end
                        end
                        default: begin
                            if (status.a_zero) begin
                                state_next = mpf_pkg::ST_PUSH;
                            end else if (status.p_two) begin
                                cmd.op     = mpf_pkg::OP_RES_ONE;
                                state_next = mpf_pkg::ST_PUSH;
                            end else begin
                                cmd.op      = mpf_pkg::OP_POW_SETUP;
                                cmd.exp_sel = mpf_pkg::EXP_PH;
                                ret_next    = mpf_pkg::ST_SQ_LEG;
                                state_next  = mpf_pkg::ST_PCHK;
                            end
                        end
                    endcase
                end
            end
            // Wait for the multiplier, then continue at the saved point.
            mpf_pkg::ST_MWAIT: begin
                if (!status.mul_busy) begin
                    state_next = after_reg;
                end
            end
            // Square-and-multiply over the exponent, low bit first.
            mpf_pkg::ST_PCHK: begin
                if (status.k_zero) begin
                    state_next = ret_reg;
                end else if (status.k_lsb) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_a     = mpf_pkg::SRC_Y;
                    cmd.mul_b     = mpf_pkg::SRC_X;
                    cmd.mul_dest  = mpf_pkg::SRC_Y;
                    after_next    = mpf_pkg::ST_PSQ;
                    state_next    = mpf_pkg::ST_MWAIT;
                end else begin
                    state_next = mpf_pkg::ST_PSQ;
                end
            end
            mpf_pkg::ST_PSQ: begin
                cmd.mul_start = 1'b1;
                cmd.mul_a     = mpf_pkg::SRC_X;
                cmd.mul_b     = mpf_pkg::SRC_X;
                cmd.mul_dest  = mpf_pkg::SRC_X;
                after_next    = mpf_pkg::ST_PSHIFT;
                state_next    = mpf_pkg::ST_MWAIT;
            end
            mpf_pkg::ST_PSHIFT: begin
                cmd.op     = mpf_pkg::OP_KSHIFT;
                state_next = mpf_pkg::ST_PCHK;
            end
            mpf_pkg::ST_POW_DONE: begin
                cmd.op     = mpf_pkg::OP_RES_Y;
                state_next = mpf_pkg::ST_PUSH;
            end
            mpf_pkg::ST_DIV_MUL: begin
                cmd.mul_start = 1'b1;
                cmd.mul_a     = mpf_pkg::SRC_A;
                cmd.mul_b     = mpf_pkg::SRC_Y;
                cmd.mul_dest  = mpf_pkg::SRC_RES;
                after_next    = mpf_pkg::ST_PUSH;
                state_next    = mpf_pkg::ST_MWAIT;
            end
            mpf_pkg::ST_LEG_DONE: begin
                cmd.op     = mpf_pkg::OP_SYM_Y;
                state_next = mpf_pkg::ST_PUSH;
            end
            // Square root: residue test, then split p-1 into q times a power of two.
            mpf_pkg::ST_SQ_LEG: begin
                if (!status.y_one) begin
                    cmd.op     = mpf_pkg::OP_ERR_NONRES;
                    state_next = mpf_pkg::ST_PUSH;
                end else begin
                    cmd.op     = mpf_pkg::OP_QINIT;
                    state_next = mpf_pkg::ST_SQ_QS;
                end
            end
            mpf_pkg::ST_SQ_QS: begin
                if (status.q_even) begin
                    cmd.op = mpf_pkg::OP_QSHIFT;
                end else if (status.s_one) begin
                    cmd.op      = mpf_pkg::OP_POW_SETUP;
                    cmd.exp_sel = mpf_pkg::EXP_P1Q;
                    ret_next    = mpf_pkg::ST_POW_DONE;
                    state_next  = mpf_pkg::ST_PCHK;
                end else begin
                    cmd.op     = mpf_pkg::OP_ZINIT;
                    cmd.cnt_op = mpf_pkg::CNT_J_ZERO;
                    state_next = mpf_pkg::ST_NR_TEST;
                end
            end
            // Search for a non-residue z.
            mpf_pkg::ST_NR_TEST: begin
                if (status.z_zero) begin
                    state_next = mpf_pkg::ST_NR_NEXT;
                end else begin
                    cmd.op       = mpf_pkg::OP_POW_SETUP;
                    cmd.base_sel = mpf_pkg::SRC_Z;
                    cmd.exp_sel  = mpf_pkg::EXP_PH;
                    ret_next     = mpf_pkg::ST_NR_CHK;
                    state_next   = mpf_pkg::ST_PCHK;
                end
            end
            mpf_pkg::ST_NR_CHK: begin
                if (!status.y_one) begin
                    cmd.op       = mpf_pkg::OP_POW_SETUP;
                    cmd.base_sel = mpf_pkg::SRC_Z;
                    cmd.exp_sel  = mpf_pkg::EXP_Q;
                    ret_next     = mpf_pkg::ST_GOT_C;
                    state_next   = mpf_pkg::ST_PCHK;
                end else begin
                    state_next = mpf_pkg::ST_NR_NEXT;
                end
            end
            mpf_pkg::ST_NR_NEXT: begin
                if (status.j_at_limit) begin
                    cmd.op     = mpf_pkg::OP_ERR_NONRES;
                    state_next = mpf_pkg::ST_PUSH;
                end else begin
                    cmd.op     = mpf_pkg::OP_ZINC;
                    cmd.cnt_op = mpf_pkg::CNT_J_INC;
                    state_next = mpf_pkg::ST_NR_TEST;
                end
            end
            // Initial c, r and t.
            mpf_pkg::ST_GOT_C: begin
                cmd.cap_en   = 1'b1;
                cmd.cap_dest = mpf_pkg::SRC_C;
                cmd.op       = mpf_pkg::OP_POW_SETUP;
                cmd.exp_sel  = mpf_pkg::EXP_QH;
                ret_next     = mpf_pkg::ST_GOT_R;
                state_next   = mpf_pkg::ST_PCHK;
            end
            mpf_pkg::ST_GOT_R: begin
                cmd.cap_en   = 1'b1;
                cmd.cap_dest = mpf_pkg::SRC_R;
                cmd.op       = mpf_pkg::OP_POW_SETUP;
                cmd.exp_sel  = mpf_pkg::EXP_Q;
                ret_next     = mpf_pkg::ST_GOT_T;
                state_next   = mpf_pkg::ST_PCHK;
            end
            mpf_pkg::ST_GOT_T: begin
                cmd.cap_en   = 1'b1;
                cmd.cap_dest = mpf_pkg::SRC_T;
                cmd.cnt_op   = mpf_pkg::CNT_M_S;
                state_next   = mpf_pkg::ST_TLOOP;
            end
            // Main loop: stop when t is one, else find the order of t.
            mpf_pkg::ST_TLOOP: begin
                if (status.t_one) begin
                    cmd.op     = mpf_pkg::OP_RES_R;
                    state_next = mpf_pkg::ST_PUSH;
                end else begin
                    cmd.cnt_op    = mpf_pkg::CNT_I_ONE;
                    cmd.mul_start = 1'b1;
                    cmd.mul_a     = mpf_pkg::SRC_T;
                    cmd.mul_b     = mpf_pkg::SRC_T;
                    cmd.mul_dest  = mpf_pkg::SRC_TS;
                    after_next    = mpf_pkg::ST_ISQ;
                    state_next    = mpf_pkg::ST_MWAIT;
                end
            end
            mpf_pkg::ST_ISQ: begin
                if (status.ts_one) begin
                    if (status.i_ge_m) begin
                        cmd.op     = mpf_pkg::OP_ERR_NONRES;
                        state_next = mpf_pkg::ST_PUSH;
                    end else begin
                        cmd.op     = mpf_pkg::OP_B_FROM_C;
                        cmd.cnt_op = mpf_pkg::CNT_J_ZERO;
                        state_next = mpf_pkg::ST_BLOOP;
                    end
                end else if (status.i1_ge_m) begin
                    cmd.op     = mpf_pkg::OP_ERR_NONRES;
                    state_next = mpf_pkg::ST_PUSH;
                end else begin
                    cmd.cnt_op    = mpf_pkg::CNT_I_INC;
                    cmd.mul_start = 1'b1;
                    cmd.mul_a     = mpf_pkg::SRC_TS;
                    cmd.mul_b     = mpf_pkg::SRC_TS;
                    cmd.mul_dest  = mpf_pkg::SRC_TS;
                    after_next    = mpf_pkg::ST_ISQ;
                    state_next    = mpf_pkg::ST_MWAIT;
                end
            end
            // Square c down to b, then update r, t, c and m.
            mpf_pkg::ST_BLOOP: begin
                cmd.mul_start = 1'b1;
                state_next    = mpf_pkg::ST_MWAIT;
                if (status.b_go) begin
                    cmd.cnt_op   = mpf_pkg::CNT_J_INC;
                    cmd.mul_a    = mpf_pkg::SRC_BV;
                    cmd.mul_b    = mpf_pkg::SRC_BV;
                    cmd.mul_dest = mpf_pkg::SRC_BV;
                    after_next   = mpf_pkg::ST_BLOOP;
                end else begin
                    cmd.mul_a    = mpf_pkg::SRC_R;
                    cmd.mul_b    = mpf_pkg::SRC_BV;
                    cmd.mul_dest = mpf_pkg::SRC_R;
                    after_next   = mpf_pkg::ST_UPD_T1;
                end
            end
            mpf_pkg::ST_UPD_T1, mpf_pkg::ST_UPD_T2: begin
                cmd.mul_start = 1'b1;
                cmd.mul_a     = mpf_pkg::SRC_T;
                cmd.mul_b     = mpf_pkg::SRC_BV;
                cmd.mul_dest  = mpf_pkg::SRC_T;
                after_next    = (state_reg == mpf_pkg::ST_UPD_T1) ? mpf_pkg::ST_UPD_T2
                                                                   : mpf_pkg::ST_UPD_C;
                state_next    = mpf_pkg::ST_MWAIT;
            end
            mpf_pkg::ST_UPD_C: begin
                cmd.cnt_op    = mpf_pkg::CNT_M_I;
                cmd.mul_start = 1'b1;
                cmd.mul_a     = mpf_pkg::SRC_BV;
                cmd.mul_b     = mpf_pkg::SRC_BV;
                cmd.mul_dest  = mpf_pkg::SRC_C;
                after_next    = mpf_pkg::ST_TLOOP;
                state_next    = mpf_pkg::ST_MWAIT;
            end
            // Hand the result to the output register once it is free.
            mpf_pkg::ST_PUSH: begin
                if (!out_valid_reg || out_ready) begin
                    cmd.op         = mpf_pkg::OP_PUSH;
                    out_valid_next = 1'b1;
                    state_next     = mpf_pkg::ST_IDLE;
                end
            end
            default: state_next = mpf_pkg::ST_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/mpf_checker.sv =====
// Port-level checks for the prime field unit, bound to the top level.
module mpf_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mpf_pkg::OUT_DATA_W-1:0]    m_tdata
);

    logic [1:0] err;
    logic [1:0] sym;
    assign err = m_tdata[mpf_pkg::ERR_LSB +: 2];
    assign sym = m_tdata[mpf_pkg::SYM_LSB +: 2];

    // A result that is not taken stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before transfer");

    // The error code never takes its unused encoding.
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> err != 2'd3)
        else $error("unused error code");

    // A flagged result carries zero value and no symbol.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && err != mpf_pkg::ERR_OK |->
            m_tdata[mpf_pkg::VALUE_BITS-1:0] == '0 && sym == mpf_pkg::SYM_ZERO)
        else $error("error result with data");

    // A Legendre symbol comes with a zero value and never takes the code 2.
    a_sym: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && sym != mpf_pkg::SYM_ZERO |->
            m_tdata[mpf_pkg::VALUE_BITS-1:0] == '0 && sym != 2'b10)
        else $error("bad symbol result");

endmodule

bind modular_prime_field_alu mpf_checker u_mpf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the prime field arithmetic unit: stream stimulus with a field predictor.
module tb_top;
    import mpf_pkg::*;

    // Expected result of one transfer.
    typedef struct {
        elem_t      value;
        logic [1:0] sym;
        logic       eq;
        logic [1:0] err;
    } field_result_t;

    localparam elem_t MAX_PRIME  = 61'h1FFF_FFFF_FFFF_FFFF;
    localparam elem_t NTT_PRIME  = 61'd998244353;
    localparam int    CYCLE_LIMIT = 4000000;
    localparam int    HOLD_CYCLES = 300;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    elem_t                 cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    field_result_t pending_results[$];
    elem_t         field_mod;
    int            mismatches;
    int            results_seen;
    int            items_sent;
    int            cycles;
    bit            idle_en;
    bit            hold_req;
    int            rx_left;

    modular_prime_field_alu dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Field arithmetic used by the predictor.
    function automatic elem_t eff_mod();
        return (field_mod < 2) ? elem_t'(2) : field_mod;
    endfunction

    function automatic elem_t fadd(input elem_t x, input elem_t y, input elem_t p);
        logic [61:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, p}) begin
            s = s - {1'b0, p};
        end
        return s[60:0];
    endfunction

    function automatic elem_t fmul(input elem_t x, input elem_t y, input elem_t p);
        logic [127:0] prod;
        prod = {67'd0, x} * {67'd0, y};
        prod = prod % {67'd0, p};
        return prod[60:0];
    endfunction

    function automatic elem_t fpow(input elem_t x, input logic [63:0] k, input elem_t p);
        elem_t y;
        y = 1 % p;
        while (k != 0) begin
            if (k[0]) begin
                y = fmul(y, x, p);
            end
            x = fmul(x, x, p);
            k = k >> 1;
        end
        return y;
    endfunction

    function automatic logic [1:0] fleg(input elem_t x, input elem_t p);
        if (x == 0) begin
            return SYM_ZERO;
        end
        if (p == 2) begin
            return SYM_POS;
        end
        return (fpow(x, (64'(p) - 1) / 2, p) == 1) ? SYM_POS : SYM_NEG;
    endfunction

    // Tonelli-Shanks with caps on the non-residue search and the order search.
    function automatic bit fsqrt(input elem_t x, input elem_t p, output elem_t root);
        logic [63:0] q;
        elem_t z, c, r, t, ts, b;
        int s, m, i, j;
        root = 0;
        if (x == 0) begin
            return 1'b1;
        end
        if (p == 2) begin
            root = 1;
            return 1'b1;
        end
        if (fleg(x, p) != SYM_POS) begin
            return 1'b0;
        end
        q = 64'(p) - 1;
        s = 0;
        while (q != 0 && !q[0]) begin
            s++;
            q = q >> 1;
        end
        if (s == 1) begin
            root = fpow(x, (64'(p) + 1) / 4, p);
            return 1'b1;
        end
        z = 2 % p;
        j = 0;
        while (fleg(z, p) != SYM_NEG) begin
            if (j >= NONRES_LIMIT) begin
                return 1'b0;
            end
            z = fadd(z, 1, p);
            j++;
        end
        c = fpow(z, q, p);
        r = fpow(x, (q + 1) / 2, p);
        t = fpow(x, q, p);
        m = s;
        while (t != 1) begin
            i = 1;
            ts = fmul(t, t, p);
            while (ts != 1) begin
                i++;
                if (i >= m) begin
                    return 1'b0;
                end
                ts = fmul(ts, ts, p);
            end
            if (i >= m) begin
                return 1'b0;
            end
            b = c;
            for (j = 0; j + i + 1 < m; j++) begin
                b = fmul(b, b, p);
            end
            r = fmul(r, b, p);
            t = fmul(t, b, p);
            t = fmul(t, b, p);
            c = fmul(b, b, p);
            m = i;
        end
        root = r;
        return 1'b1;
    endfunction

    // Expected result of one item under the current modulus.
    function automatic field_result_t predict_field_op(input mode_t md, input elem_t a,
                                                       input elem_t b, input exp_t k);
        field_result_t res;
        elem_t p;
        bit uses_b;
        p = eff_mod();
        uses_b = (md == MODE_ADD || md == MODE_SUB || md == MODE_MUL || md == MODE_DIV);
        res.value = 0;
        res.sym = SYM_ZERO;
        res.err = ERR_OK;
        res.eq = (a == b);
        if (a >= p || (uses_b && b >= p)) begin
            res.err = ERR_RANGE;
        end else begin
            case (md)
                MODE_ADD: res.value = fadd(a, b, p);
                MODE_SUB: res.value = (a >= b) ? a - b : a + (p - b);
                MODE_MUL: res.value = fmul(a, b, p);
                MODE_NEG: res.value = (a != 0) ? p - a : 0;
                MODE_POW: res.value = fpow(a, k, p);
                MODE_DIV: res.value = fmul(a, fpow(b, 64'(p) - 2, p), p);
                MODE_LEG: res.sym = fleg(a, p);
                default: begin
                    if (!fsqrt(a, p, res.value)) begin
                        res.value = 0;
                        res.err = ERR_NONRES;
                    end
                end
            endcase
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    // Send one item; the expectation is queued when the transfer is certain.
    task automatic send_item(input mode_t md, input elem_t a, input elem_t b, input exp_t k);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - IN_BITS){1'b0}}, k, b, a, md};
        do @(negedge aclk); while (!s_tready);
        pending_results.push_back(predict_field_op(md, a, b, k));
        items_sent++;
        @(posedge aclk);
    endtask

    // Drain the unit, then write a new modulus.
    task automatic set_modulus(input elem_t v);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        field_mod = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic elem_t rand_elem(input elem_t p);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return elem_t'(r % 64'(p));
    endfunction

    function automatic elem_t rand_raw();
        return elem_t'({$urandom, $urandom});
    endfunction

    // Extremes, every operation and the special cases.
    task automatic test_directed();
        elem_t pm;
        set_modulus(MAX_PRIME);
        pm = MAX_PRIME - 1;
        send_item(MODE_ADD, pm, pm, 0);
        send_item(MODE_SUB, 0, pm, 0);
        send_item(MODE_MUL, pm, pm, 0);
        send_item(MODE_NEG, 0, 5, 0);
        send_item(MODE_NEG, 1, MAX_PRIME, 0);
        send_item(MODE_POW, 0, 0, 0);
        send_item(MODE_POW, 3, 0, '1);
        send_item(MODE_DIV, 7, 0, 0);
        send_item(MODE_DIV, pm, 3, 0);
        send_item(MODE_LEG, 0, 0, 0);
        send_item(MODE_LEG, pm, 1, 0);
        send_item(MODE_SQRT, 0, 0, 0);
        send_item(MODE_SQRT, 4, 0, 0);
        send_item(MODE_SQRT, pm, 0, 0);
        send_item(MODE_ADD, '1, 1, 0);
        send_item(MODE_SUB, 1, '1, 0);
        send_item(MODE_POW, 2, '1, 5);
        // A modulus below two behaves as two.
        set_modulus(0);
        send_item(MODE_ADD, 1, 1, 0);
        send_item(MODE_LEG, 1, 0, 0);
        send_item(MODE_SQRT, 1, 0, 0);
        set_modulus(NTT_PRIME);
        send_item(MODE_SQRT, 2, 0, 0);
        send_item(MODE_SQRT, 5, 0, 0);
        // Composite modulus exercises the capped root search.
        set_modulus(9);
        send_item(MODE_SQRT, 7, 0, 0);
        send_item(MODE_SQRT, 4, 0, 0);
        set_modulus(15);
        send_item(MODE_SQRT, 4, 0, 0);
    endtask

    // Random items, mostly well-formed, under the given modulus.
    task automatic test_random(input elem_t p, input int count);
        mode_t md;
        elem_t a, b;
        exp_t  k;
        set_modulus(p);
        repeat (count) begin
            md = mode_t'($urandom_range(0, 7));
            a = rand_elem(p);
            b = ($urandom_range(0, 7) == 0) ? a : rand_elem(p);
            k = exp_t'({$urandom, $urandom} >> $urandom_range(1, 60));
            if (md == MODE_POW && $urandom_range(0, 3) == 0) begin
                k = exp_t'({$urandom, $urandom});
            end
            if ($urandom_range(0, 9) == 0) begin
                a = rand_raw();
            end
            if ($urandom_range(0, 9) == 0) begin
                b = rand_raw();
            end
            send_item(md, a, b, k);
        end
    endtask

    // The receiver holds off while fast items keep coming.
    task automatic test_backpressure();
        set_modulus(97);
        hold_req = 1'b1;
        repeat (10) send_item(MODE_ADD, rand_elem(97), rand_elem(97), 0);
    endtask

    // Receiver readiness: random bursts, a long hold on request.
    always @(posedge aclk) begin
        if (rx_left > 0) begin
            rx_left <= rx_left - 1;
        end else if (hold_req) begin
            m_tready <= 1'b0;
            rx_left  <= HOLD_CYCLES;
            hold_req = 1'b0;
        end else if (!idle_en) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= $urandom_range(0, 1);
            rx_left  <= $urandom_range(0, 16);
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(negedge aclk) begin
        field_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no item outstanding");
            end else begin
                exp_res = pending_results.pop_front();
                if (m_tdata[VALUE_BITS-1:0] !== exp_res.value) begin
                    report_mismatch($sformatf("value %0d, expected %0d",
                                              m_tdata[VALUE_BITS-1:0], exp_res.value));
                end
                if (m_tdata[SYM_LSB+:2] !== exp_res.sym) begin
                    report_mismatch($sformatf("symbol %b, expected %b",
                                              m_tdata[SYM_LSB+:2], exp_res.sym));
                end
                if (m_tdata[EQ_BIT] !== exp_res.eq) begin
                    report_mismatch($sformatf("equal %b, expected %b",
                                              m_tdata[EQ_BIT], exp_res.eq));
                end
                if (m_tdata[ERR_LSB+:2] !== exp_res.err) begin
                    report_mismatch($sformatf("error %0d, expected %0d",
                                              m_tdata[ERR_LSB+:2], exp_res.err));
                end
            end
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        field_mod   = 2;
        mismatches  = 0;
        results_seen = 0;
        items_sent  = 0;
        cycles      = 0;
        idle_en     = 1'b1;
        hold_req    = 1'b0;
        rx_left     = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(MAX_PRIME, 10);
        test_random(NTT_PRIME, 10);
        test_random(13, 15);
        test_backpressure();
        test_random(2, 10);
        test_random(65537, 15);
        // Last part runs with both sides always ready.
        idle_en = 1'b0;
        test_random(97, 15);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Covered %0d items and %0d results over moduli 0, 2, 9, 13, 15, 97,",
                 items_sent, results_seen);
        $display("65537, 998244353 and 2^61-1, with all eight operations and backpressure.");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mpf_pkg.sv
rtl/core/mpf_datapath.sv
rtl/core/mpf_ctrl.sv
rtl/core/modular_prime_field_alu.sv
rtl/core/mpf_checker.sv
tb/tb_top.sv
